@@ hw/rtl/adc_slice_packet_framer_assert.svh @@
// ----------------------------------------------------------------------------
// ADC slice packet framer assertion macros
// Shared property wrappers for the framer's checker.
// ----------------------------------------------------------------------------
`ifndef ADC_SLICE_PACKET_FRAMER_ASSERT_SVH
`define ADC_SLICE_PACKET_FRAMER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define ASFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("framer assertion failed");

// next-cycle implication
`define ASFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("framer assertion failed");

`endif

@@ hw/rtl/asfr_pkg.sv @@
// ----------------------------------------------------------------------------
// asfr_pkg
// Types and constants shared by the ADC slice packet framer.
// ----------------------------------------------------------------------------
package asfr_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_W = 31;

  // configuration register indexes
  localparam logic [1:0] REG_SAMPLES_PER_SLICE = 2'd0;
  localparam logic [1:0] REG_SLICES_PER_PACKET = 2'd1;
  localparam logic [1:0] REG_SLICE_SIZE_WORD   = 2'd2;

  localparam logic [15:0] RST_SAMPLES_PER_SLICE = 16'd2042;
  localparam logic [7:0]  RST_SLICES_PER_PACKET = 8'd2;
  localparam logic [30:0] RST_SLICE_SIZE_WORD   = 31'd6;

  // word kinds
  localparam logic [1:0] KIND_PKT_HDR   = 2'd0;
  localparam logic [1:0] KIND_TRIG_HDR  = 2'd1;
  localparam logic [1:0] KIND_SLICE_HDR = 2'd2;
  localparam logic [1:0] KIND_SAMPLE    = 2'd3;

  // word positions within a full 28-word run
  localparam int POS_W = 5;
  localparam logic [POS_W-1:0] POS_PKT_CNT_HI = 5'd0;
  localparam logic [POS_W-1:0] POS_PKT_CNT_LO = 5'd1;
  localparam logic [POS_W-1:0] POS_TRIG_HDR   = 5'd3;
  localparam logic [POS_W-1:0] POS_SLICE_HDR  = 5'd19;
  localparam logic [POS_W-1:0] POS_SLC_CNT_LO = 5'd20;
  localparam logic [POS_W-1:0] POS_IDX_3      = 5'd21;
  localparam logic [POS_W-1:0] POS_IDX_2      = 5'd22;
  localparam logic [POS_W-1:0] POS_IDX_1      = 5'd23;
  localparam logic [POS_W-1:0] POS_IDX_0      = 5'd24;
  localparam logic [POS_W-1:0] POS_SIZE_HI    = 5'd25;
  localparam logic [POS_W-1:0] POS_SIZE_LO    = 5'd26;
  localparam logic [POS_W-1:0] POS_SAMPLE     = 5'd27;

  // one classified sample with the counter snapshot its headers need
  typedef struct packed {
    logic [15:0] sample;
    logic        pkt_hdr;
    logic        slc_hdr;
    logic [31:0] pkt_cnt;
    logic [31:0] slc_cnt;
    logic [63:0] smp_idx;
  } asfr_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } asfr_q_status_t;

endpackage

@@ hw/rtl/asfr_front.sv @@
// ----------------------------------------------------------------------------
// asfr_front
// Accepts samples, tracks slice/packet position and snapshots the counters.
// ----------------------------------------------------------------------------
module asfr_front
  import asfr_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [15:0]    sample,
  input  logic [15:0]    samples_per_slice,
  input  logic [7:0]     slices_per_packet,
  input  asfr_q_status_t q_status,
  output logic           push,
  output asfr_desc_t     desc
);

  logic [31:0] packet_count;
  logic [31:0] slice_count;
  logic [63:0] sample_index;
  logic [7:0]  slice_in_packet;
  logic [15:0] sample_in_slice;

  logic [16:0] sis_inc;
  logic [8:0]  sip_inc;
  logic        slice_end;
  logic        pkt_end;

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  assign desc.sample  = sample;
  assign desc.slc_hdr = (sample_in_slice == 16'd0);
  assign desc.pkt_hdr = (sample_in_slice == 16'd0) && (slice_in_packet == 8'd0);
  assign desc.pkt_cnt = packet_count;
  assign desc.slc_cnt = slice_count;
  assign desc.smp_idx = sample_index;

  // a zero register compares as always reached, which gives the act-as-one rule
  assign sis_inc   = {1'b0, sample_in_slice} + 17'd1;
  assign slice_end = (sis_inc >= {1'b0, samples_per_slice});
  assign sip_inc   = {1'b0, slice_in_packet} + 9'd1;
  assign pkt_end   = (sip_inc >= {1'b0, slices_per_packet});

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_count    <= '0;
      slice_count     <= '0;
      sample_index    <= '0;
      slice_in_packet <= '0;
      sample_in_slice <= '0;
    end else if (push) begin
      sample_index <= sample_index + 64'd1;
      if (desc.pkt_hdr) begin
        packet_count <= packet_count + 32'd1;
      end
      if (slice_end) begin
        sample_in_slice <= '0;
        slice_count     <= slice_count + 32'd1;
        slice_in_packet <= pkt_end ? 8'd0 : sip_inc[7:0];
      end else begin
        sample_in_slice <= sis_inc[15:0];
      end
    end
  end

endmodule

@@ hw/rtl/asfr_queue.sv @@
// ----------------------------------------------------------------------------
// asfr_queue
// Short descriptor queue between the front and the word emitter.
// ----------------------------------------------------------------------------
module asfr_queue
  import asfr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  asfr_desc_t     wr_desc,
  input  logic           pop,
  output asfr_desc_t     head,
  output asfr_q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  asfr_desc_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/asfr_back.sv @@
// ----------------------------------------------------------------------------
// asfr_back
// Expands each queued descriptor into its run of output words.
// ----------------------------------------------------------------------------
module asfr_back
  import asfr_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  asfr_desc_t     head,
  input  asfr_q_status_t q_status,
  output logic           pop,
  input  logic [30:0]    slice_size_word,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [15:0]    data_word,
  output logic [1:0]     word_kind,
  output logic           last_of_run
);

  logic [POS_W-1:0] pos;
  logic             started;

  logic [POS_W-1:0] start_pos;
  logic [POS_W-1:0] cur_pos;
  logic             load;
  logic             emit;
  logic [15:0]      word;
  logic [1:0]       kind;

  assign load = !out_valid || out_ready;
  assign emit = load && !q_status.empty;
  assign pop  = emit && (cur_pos == POS_SAMPLE);

  always_comb begin
    if (head.pkt_hdr) begin
      start_pos = POS_PKT_CNT_HI;
    end else if (head.slc_hdr) begin
      start_pos = POS_SLICE_HDR;
    end else begin
      start_pos = POS_SAMPLE;
    end
  end

  assign cur_pos = started ? pos : start_pos;

  always_comb begin
    case (cur_pos)
      POS_PKT_CNT_HI: word = head.pkt_cnt[31:16];
      POS_PKT_CNT_LO: word = head.pkt_cnt[15:0];
      POS_TRIG_HDR:   word = head.pkt_cnt[15:0];
      POS_SLICE_HDR:  word = head.slc_cnt[31:16];
      POS_SLC_CNT_LO: word = head.slc_cnt[15:0];
      POS_IDX_3:      word = head.smp_idx[63:48];
      POS_IDX_2:      word = head.smp_idx[47:32];
      POS_IDX_1:      word = head.smp_idx[31:16];
      POS_IDX_0:      word = head.smp_idx[15:0];
      POS_SIZE_HI:    word = {1'b0, slice_size_word[30:16]};
      POS_SIZE_LO:    word = slice_size_word[15:0];
      POS_SAMPLE:     word = head.sample;
      default:        word = 16'd0; // zero fill in packet and trigger headers
    endcase
  end

  always_comb begin
    if (cur_pos < POS_TRIG_HDR) begin
      kind = KIND_PKT_HDR;
    end else if (cur_pos < POS_SLICE_HDR) begin
      kind = KIND_TRIG_HDR;
    end else if (cur_pos < POS_SAMPLE) begin
      kind = KIND_SLICE_HDR;
    end else begin
      kind = KIND_SAMPLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= !q_status.empty;
      end
      if (emit) begin
        if (cur_pos == POS_SAMPLE) begin
          started <= 1'b0;
        end else begin
          started <= 1'b1;
          pos     <= cur_pos + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      data_word   <= word;
      word_kind   <= kind;
      last_of_run <= (cur_pos == POS_SAMPLE);
    end
  end

endmodule

@@ hw/rtl/adc_slice_packet_framer.sv @@
// A sample accepted into an empty block is queued, then its first word is registered at
// the output. Input: one sample per cycle while the queue has room; the emitter drains
// one word per cycle unless stalled; runs are 1, 9 or 28 words; the queue absorbs bursts.
// Reset: counters clear, registers load their defaults, the queue and output empty at once.
// ----------------------------------------------------------------------------
// adc_slice_packet_framer
// Frames signed ADC samples into packets with packet, trigger and slice headers.
// ----------------------------------------------------------------------------
module adc_slice_packet_framer
  import asfr_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [15:0]      sample,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [15:0]      data_word,
  output logic [1:0]       word_kind,
  output logic             last_of_run,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [15:0] samples_per_slice;
  logic [7:0]  slices_per_packet;
  logic [30:0] slice_size_word;

  asfr_desc_t     push_desc;
  asfr_desc_t     head;
  asfr_q_status_t q_status;
  logic           push;
  logic           pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_slice <= RST_SAMPLES_PER_SLICE;
      slices_per_packet <= RST_SLICES_PER_PACKET;
      slice_size_word   <= RST_SLICE_SIZE_WORD;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLES_PER_SLICE: samples_per_slice <= cfg_data[15:0];
        REG_SLICES_PER_PACKET: slices_per_packet <= cfg_data[7:0];
        REG_SLICE_SIZE_WORD:   slice_size_word   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  asfr_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .sample            (sample),
    .samples_per_slice (samples_per_slice),
    .slices_per_packet (slices_per_packet),
    .q_status          (q_status),
    .push              (push),
    .desc              (push_desc)
  );

  asfr_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_desc (push_desc),
    .pop     (pop),
    .head    (head),
    .status  (q_status)
  );

  asfr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .q_status        (q_status),
    .pop             (pop),
    .slice_size_word (slice_size_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .data_word       (data_word),
    .word_kind       (word_kind),
    .last_of_run     (last_of_run)
  );

endmodule

@@ hw/rtl/asfr_checker.sv @@
// ----------------------------------------------------------------------------
// asfr_checker
// Port-level checks on the framer's output word stream.
// ----------------------------------------------------------------------------
`include "adc_slice_packet_framer_assert.svh"

module asfr_checker
  import asfr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] data_word,
  input logic [1:0]  word_kind,
  input logic        last_of_run
);

  logic       out_xfer;
  logic [1:0] prev_kind;

  assign out_xfer = out_valid && out_ready;

  // kind of the previous output transfer; a run boundary looks like a sample
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_kind <= KIND_SAMPLE;
    end else if (out_xfer) begin
      prev_kind <= word_kind;
    end
  end

  `ASFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(data_word) && $stable(word_kind) && $stable(last_of_run))
  `ASFR_ASSERT_NOW(a_last_is_sample, out_xfer,
    last_of_run == (word_kind == KIND_SAMPLE))
  `ASFR_ASSERT_NOW(a_trig_order, out_xfer && (word_kind == KIND_TRIG_HDR),
    (prev_kind == KIND_PKT_HDR) || (prev_kind == KIND_TRIG_HDR))
  `ASFR_ASSERT_NOW(a_pkt_order, out_xfer && (word_kind == KIND_PKT_HDR),
    (prev_kind == KIND_PKT_HDR) || (prev_kind == KIND_SAMPLE))

endmodule

bind adc_slice_packet_framer asfr_checker u_checker (.*);
